>>> sv/sfl_pkg.sv
// Package for the scoped frame layout unit: widths, event and status codes,
// and the item carried from the input stage to the layout core. No dependencies.
`timescale 1ns / 1ps

package sfl_pkg;

  localparam int SCOPE_DEPTH = 16;
  localparam int MAX_LOCALS  = 65536;

  localparam int CNT_W    = $clog2(SCOPE_DEPTH + 1);
  localparam int IDX_W    = $clog2(SCOPE_DEPTH);
  localparam int LOC_W    = $clog2(MAX_LOCALS + 1);

  localparam int KIND_W   = 2;
  localparam int VAL_W    = 24;
  localparam int SIZE_W   = VAL_W + 3;
  localparam int ALIGN_W  = VAL_W + 1;
  localparam int DATA_W   = 32;
  localparam int INDEX_W  = 16;
  localparam int STATUS_W = 3;

  // word sizes as shift amounts: four and eight bytes
  localparam int WORD_SHIFT_NARROW = 2;
  localparam int WORD_SHIFT_WIDE   = 3;

  localparam logic [KIND_W-1:0] KIND_ENTER   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LEAVE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PLACE   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LOCALS   = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SIZE_W-1:0]  size;
    logic [ALIGN_W-1:0] align;
    logic [ALIGN_W-1:0] mask;   // align - 1
  } item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  local_index;
    logic [DATA_W-1:0]   local_offset;
    logic [DATA_W-1:0]   frame_size;
    logic [ALIGN_W-1:0]  frame_alignment;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

>>> sv/sfl_prep.sv
// Input stage: registers one event and derives the local's size and alignment.
// Depends on sfl_pkg.
`timescale 1ns / 1ps

module sfl_prep (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        arch_mode,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sfl_pkg::KIND_W-1:0]  kind,
  input  logic                        size_in_words,
  input  logic [sfl_pkg::VAL_W-1:0]   size_value,
  output logic                        item_valid,
  input  logic                        core_ready,
  output sfl_pkg::item_t              item
);

  sfl_pkg::item_t               item_next;
  logic [sfl_pkg::VAL_W-1:0]    word_bytes;
  logic [sfl_pkg::VAL_W-1:0]    byte_floor;
  logic [sfl_pkg::VAL_W-1:0]    smear;

  assign word_bytes = arch_mode ? sfl_pkg::VAL_W'(1 << sfl_pkg::WORD_SHIFT_WIDE)
                                : sfl_pkg::VAL_W'(1 << sfl_pkg::WORD_SHIFT_NARROW);

  always_comb begin
    byte_floor = (size_value > word_bytes) ? size_value : word_bytes;
    // next power of two: smear the bits of (v - 1) downward, then add one
    smear = byte_floor - sfl_pkg::VAL_W'(1);
    for (int i = 0; i < 5; i++) begin
      smear = smear | (smear >> (1 << i));
    end
    item_next.kind = kind;
    if (size_in_words) begin
      item_next.size  = arch_mode
                      ? (sfl_pkg::SIZE_W'(size_value) << sfl_pkg::WORD_SHIFT_WIDE)
                      : (sfl_pkg::SIZE_W'(size_value) << sfl_pkg::WORD_SHIFT_NARROW);
      item_next.align = sfl_pkg::ALIGN_W'(word_bytes);
      item_next.mask  = sfl_pkg::ALIGN_W'(word_bytes) - sfl_pkg::ALIGN_W'(1);
    end else begin
      item_next.size  = sfl_pkg::SIZE_W'(size_value);
      item_next.align = sfl_pkg::ALIGN_W'(smear) + sfl_pkg::ALIGN_W'(1);
      item_next.mask  = sfl_pkg::ALIGN_W'(smear);
    end
  end

  assign in_ready = !item_valid || core_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

>>> sv/sfl_core.sv
// Layout core: scope stack, running and peak sizes, local counter and the
// result register. Depends on sfl_pkg.
`timescale 1ns / 1ps

module sfl_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              core_ready,
  input  sfl_pkg::item_t    item,
  output logic              res_valid,
  input  logic              res_ready,
  output sfl_pkg::result_t  res
);

  logic [sfl_pkg::DATA_W-1:0]  stack [sfl_pkg::SCOPE_DEPTH];
  logic [sfl_pkg::CNT_W-1:0]   saved_count, saved_count_next, count_dec;
  logic [sfl_pkg::DATA_W-1:0]  running_size, running_size_next;
  logic [sfl_pkg::DATA_W-1:0]  peak_size, peak_size_next;
  logic [sfl_pkg::ALIGN_W-1:0] peak_alignment, peak_alignment_next;
  logic [sfl_pkg::LOC_W-1:0]   next_local, next_local_next;
  logic                        stack_we, stack_clr, fire;
  logic [sfl_pkg::DATA_W:0]    aligned;
  logic [sfl_pkg::DATA_W+1:0]  end_sum;
  sfl_pkg::result_t            res_next;

  assign core_ready = !res_valid || res_ready;
  assign fire       = item_valid && core_ready;
  assign count_dec  = saved_count - sfl_pkg::CNT_W'(1);

  always_comb begin
    aligned = ({1'b0, running_size} + (sfl_pkg::DATA_W + 1)'(item.mask))
            & ~((sfl_pkg::DATA_W + 1)'(item.mask));
    end_sum = {1'b0, aligned} + (sfl_pkg::DATA_W + 2)'(item.size);

    saved_count_next    = saved_count;
    running_size_next   = running_size;
    peak_size_next      = peak_size;
    peak_alignment_next = peak_alignment;
    next_local_next     = next_local;
    stack_we            = 1'b0;
    stack_clr           = 1'b0;
    res_next.local_index  = '0;
    res_next.local_offset = '0;
    res_next.status       = sfl_pkg::ST_OK;

    unique case (item.kind)
      sfl_pkg::KIND_ENTER: begin
        if (saved_count >= sfl_pkg::CNT_W'(sfl_pkg::SCOPE_DEPTH)) begin
          res_next.status = sfl_pkg::ST_FULL;
        end else begin
          stack_we         = 1'b1;
          saved_count_next = saved_count + sfl_pkg::CNT_W'(1);
        end
      end
      sfl_pkg::KIND_LEAVE: begin
        if (saved_count == '0) begin
          res_next.status = sfl_pkg::ST_EMPTY;
        end else begin
          saved_count_next  = count_dec;
          running_size_next = stack[count_dec[sfl_pkg::IDX_W-1:0]];
        end
      end
      sfl_pkg::KIND_PLACE: begin
        priority if (next_local >= sfl_pkg::LOC_W'(sfl_pkg::MAX_LOCALS)) begin
          res_next.status = sfl_pkg::ST_LOCALS;
        end else if (end_sum[sfl_pkg::DATA_W+1:sfl_pkg::DATA_W] != 2'b00) begin
          res_next.status = sfl_pkg::ST_OVERFLOW;
        end else begin
          res_next.local_index  = sfl_pkg::INDEX_W'(next_local);
          res_next.local_offset = aligned[sfl_pkg::DATA_W-1:0];
          next_local_next   = next_local + sfl_pkg::LOC_W'(1);
          running_size_next = end_sum[sfl_pkg::DATA_W-1:0];
          if (end_sum[sfl_pkg::DATA_W-1:0] > peak_size) begin
            peak_size_next = end_sum[sfl_pkg::DATA_W-1:0];
          end
          if (item.align > peak_alignment) begin
            peak_alignment_next = item.align;
          end
        end
      end
      sfl_pkg::KIND_RESTART: begin
        stack_clr           = 1'b1;
        saved_count_next    = sfl_pkg::CNT_W'(1);
        running_size_next   = '0;
        peak_size_next      = '0;
        peak_alignment_next = '0;
        next_local_next     = '0;
      end
      default: ;
    endcase

    res_next.frame_size      = peak_size_next;
    res_next.frame_alignment = peak_alignment_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saved_count    <= sfl_pkg::CNT_W'(1);
      running_size   <= '0;
      peak_size      <= '0;
      peak_alignment <= '0;
      next_local     <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (fire) begin
        saved_count    <= saved_count_next;
        running_size   <= running_size_next;
        peak_size      <= peak_size_next;
        peak_alignment <= peak_alignment_next;
        next_local     <= next_local_next;
        res_valid      <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // only the base entry has a defined value before it is written
  always_ff @(posedge clk) begin
    if (rst || (fire && stack_clr)) begin
      stack[0] <= '0;
    end else if (fire && stack_we) begin
      stack[saved_count[sfl_pkg::IDX_W-1:0]] <= running_size;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    saved_count <= sfl_pkg::CNT_W'(sfl_pkg::SCOPE_DEPTH))
    else $error("scope count beyond stack depth");

  a_locals_bound : assert property (@(posedge clk) disable iff (rst)
    next_local <= sfl_pkg::LOC_W'(sfl_pkg::MAX_LOCALS))
    else $error("local counter beyond limit");

  a_running_le_peak : assert property (@(posedge clk) disable iff (rst)
    running_size <= peak_size)
    else $error("running size above peak");

  a_align_pow2 : assert property (@(posedge clk) disable iff (rst)
    $onehot0(peak_alignment))
    else $error("peak alignment not a power of two");

  a_error_zero : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != sfl_pkg::ST_OK)
      |-> (res.local_index == '0 && res.local_offset == '0))
    else $error("failed request carries index or offset");

endmodule

>>> sv/scoped_frame_layout_unit.sv
// Top level of the scoped frame layout unit: stream ports, word-size register,
// input stage and layout core. Depends on sfl_pkg, sfl_prep, sfl_core.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tdata: size_value; tuser: kind, size_in_words
//  m_*     | out | m_tvalid/m_tready  | tdata: index, offset, frame size, alignment, status
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_data: arch_mode (word size)
//
// One request per cycle sustained while m_tready is high; a request that is taken is
// held in the input register, then the core's single-pass update writes its result into
// the result register. Reset clears the frame state, sets eight-byte words and empties
// both registers. With m_tready low the result holds; s_tready drops only once the input
// register is also full. cfg_ready is always high.
`timescale 1ns / 1ps

module scoped_frame_layout_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [23:0]   s_tdata,   // [23:0] size_value
  input  logic [2:0]    s_tuser,   // [1:0] kind, [2] size_in_words
  output logic          m_tvalid,
  input  logic          m_tready,
  // [15:0] local_index, [47:16] local_offset, [79:48] frame_size,
  // [104:80] frame_alignment, [107:105] status, [111:108] zero
  output logic [111:0]  m_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data
);

  logic              arch_mode;
  logic              item_valid;
  logic              core_ready;
  sfl_pkg::item_t    item;
  sfl_pkg::result_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      arch_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      arch_mode <= cfg_data;
    end
  end

  sfl_prep u_prep (
    .clk           (clk),
    .rst           (rst),
    .arch_mode     (arch_mode),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .kind          (s_tuser[1:0]),
    .size_in_words (s_tuser[2]),
    .size_value    (s_tdata),
    .item_valid    (item_valid),
    .core_ready    (core_ready),
    .item          (item)
  );

  sfl_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .core_ready (core_ready),
    .item       (item),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = {4'b0000, res.status, res.frame_alignment, res.frame_size,
                    res.local_offset, res.local_index};

endmodule
